// ===== rtl/sfrc_pkg.sv =====
// Shared constants for the serial frame receiver with CRC-16 check.
// No dependencies; every other file in this block except sfrc_req_if refers to it by scoped names.
`default_nettype none

package sfrc_pkg;

   localparam int MaxPayload    = 8;
   localparam int BufIndexWidth = $clog2(MaxPayload);
   localparam int LengthWidth   = 4;
   localparam int PayloadWidth  = 64;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 8;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   localparam logic [7:0] HeadByteReset    = 8'hAA;
   localparam logic [7:0] CommandTypeReset = 8'h01;
   localparam logic [7:0] DataTypeReset    = 8'h02;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrHeadByte    = 2'd0,
      CsrCommandType = 2'd1,
      CsrDataType    = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/sfrc_req_if.sv =====
// Receive byte channel: valid/ready handshake carrying one serial byte.
// Depends on nothing.
`default_nettype none

interface sfrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfrc_rsp_if.sv =====
// Frame result channel: valid/ready handshake carrying kind, length and payload.
// Depends on sfrc_pkg for field widths.
`default_nettype none

interface sfrc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             frame_kind;
   logic [sfrc_pkg::LengthWidth-1:0] payload_length;
   logic [sfrc_pkg::PayloadWidth-1:0] payload;

   modport source (output valid, output frame_kind, output payload_length, output payload,
                   input ready);
   modport sink (input valid, input frame_kind, input payload_length, input payload,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/sfrc_crc16_step.sv =====
// One byte of CRC-16/MODBUS update (reflected polynomial, eight bit steps).
// Depends on sfrc_pkg for the polynomial.
`default_nettype none

module sfrc_crc16_step (
   input  wire logic [15:0] crc_in,
   input  wire logic [7:0]  data_byte,
   output logic      [15:0] crc_out
);

   always_comb begin
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ sfrc_pkg::CrcPoly;
         end else begin
            crc = crc >> 1;
         end
      end
      crc_out = crc;
   end

endmodule

`default_nettype wire

// ===== rtl/serial_frame_receive_crc_check.sv =====
// Serial frame receiver: deframes head/type/length/payload/CRC and checks CRC-16/MODBUS.
// Depends on sfrc_pkg, sfrc_req_if, sfrc_rsp_if and sfrc_crc16_step.
//
// Takes one received byte per cycle; each byte is handled in the cycle it is
// accepted and a good frame appears on the result channel the cycle after its
// last CRC byte. A finished frame waits in the output register while later
// bytes keep flowing; input stalls only when that register is full and the
// result side is not taking it. Frames with a bad type, a length above eight
// or a CRC mismatch produce nothing. Configuration writes take effect on the
// next byte.
`default_nettype none

module serial_frame_receive_crc_check (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [sfrc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [sfrc_pkg::CsrDataWidth-1:0]  csr_write_data,
   sfrc_req_if.sink                                req_bus,
   sfrc_rsp_if.source                              rsp_bus
);

   typedef enum logic [2:0] {
      PhaseIdle,
      PhaseType,
      PhaseLenHigh,
      PhaseLenLow,
      PhaseData,
      PhaseCrcHigh,
      PhaseCrcLow
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [7:0]  head_byte_ff, command_type_ff, data_type_ff;
   logic        kind_ff, kind_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [sfrc_pkg::LengthWidth-1:0] length_ff, length_in;
   logic [sfrc_pkg::LengthWidth-1:0] byte_index_ff, byte_index_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  data_buffer_ff [sfrc_pkg::MaxPayload];
   logic        buffer_write;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [sfrc_pkg::LengthWidth-1:0]  rsp_length_ff;
   logic [sfrc_pkg::PayloadWidth-1:0] rsp_payload_ff, payload_in;

   logic        accept;
   logic        emit;
   logic [7:0]  rx;
   logic [15:0] crc_step_out;
   logic [15:0] full_length;

   assign rx             = req_bus.rx_byte;
   assign req_bus.ready  = !rsp_valid_ff || rsp_bus.ready;
   assign accept         = req_bus.valid && req_bus.ready;
   assign full_length    = {length_high_ff, rx};

   sfrc_crc16_step u_crc_step (
      .crc_in    (running_crc_ff),
      .data_byte (rx),
      .crc_out   (crc_step_out)
   );

   always_comb begin
      phase_in       = phase_ff;
      kind_in        = kind_ff;
      length_high_in = length_high_ff;
      length_in      = length_ff;
      byte_index_in  = byte_index_ff;
      crc_high_in    = crc_high_ff;
      running_crc_in = running_crc_ff;
      buffer_write   = 1'b0;
      emit           = 1'b0;
      if (accept) begin
         case (phase_ff)
            PhaseIdle: begin
               if (rx == head_byte_ff) begin
                  phase_in = PhaseType;
               end
            end
            PhaseType: begin
               if (rx == command_type_ff || rx == data_type_ff) begin
                  kind_in        = (rx != command_type_ff);
                  byte_index_in  = '0;
                  running_crc_in = sfrc_pkg::CrcInit;
                  phase_in       = PhaseLenHigh;
               end else begin
                  phase_in = PhaseIdle;
               end
            end
            PhaseLenHigh: begin
               length_high_in = rx;
               phase_in       = PhaseLenLow;
            end
            PhaseLenLow: begin
               length_in = full_length[sfrc_pkg::LengthWidth-1:0];
               if (full_length > 16'(sfrc_pkg::MaxPayload)) begin
                  phase_in = PhaseIdle;
               end else if (full_length != 16'd0) begin
                  phase_in = PhaseData;
               end else begin
                  phase_in = PhaseCrcHigh;
               end
            end
            PhaseData: begin
               buffer_write   = (byte_index_ff < sfrc_pkg::LengthWidth'(sfrc_pkg::MaxPayload));
               byte_index_in  = byte_index_ff + 1'b1;
               running_crc_in = crc_step_out;
               if (byte_index_in >= length_ff) begin
                  phase_in = PhaseCrcHigh;
               end
            end
            PhaseCrcHigh: begin
               crc_high_in = rx;
               phase_in    = PhaseCrcLow;
            end
            PhaseCrcLow: begin
               emit     = ({crc_high_ff, rx} == running_crc_ff);
               phase_in = PhaseIdle;
            end
            default: begin
               phase_in = PhaseIdle;
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < sfrc_pkg::MaxPayload; i++) begin
         payload_in[8*i +: 8] = (sfrc_pkg::LengthWidth'(i) < length_ff) ? data_buffer_ff[i] : 8'h00;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PhaseIdle;
         kind_ff         <= 1'b0;
         length_high_ff  <= '0;
         length_ff       <= '0;
         byte_index_ff   <= '0;
         crc_high_ff     <= '0;
         running_crc_ff  <= sfrc_pkg::CrcInit;
         rsp_valid_ff    <= 1'b0;
         head_byte_ff    <= sfrc_pkg::HeadByteReset;
         command_type_ff <= sfrc_pkg::CommandTypeReset;
         data_type_ff    <= sfrc_pkg::DataTypeReset;
      end else begin
         phase_ff       <= phase_in;
         kind_ff        <= kind_in;
         length_high_ff <= length_high_in;
         length_ff      <= length_in;
         byte_index_ff  <= byte_index_in;
         crc_high_ff    <= crc_high_in;
         running_crc_ff <= running_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               sfrc_pkg::CsrHeadByte:    head_byte_ff    <= csr_write_data;
               sfrc_pkg::CsrCommandType: command_type_ff <= csr_write_data;
               sfrc_pkg::CsrDataType:    data_type_ff    <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // hold payload data; no reset needed
   always_ff @(posedge clock) begin
      if (buffer_write) begin
         data_buffer_ff[byte_index_ff[sfrc_pkg::BufIndexWidth-1:0]] <= rx;
      end
      if (emit) begin
         rsp_kind_ff    <= kind_ff;
         rsp_length_ff  <= length_ff;
         rsp_payload_ff <= payload_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.frame_kind     = rsp_kind_ff;
   assign rsp_bus.payload_length = rsp_length_ff;
   assign rsp_bus.payload        = rsp_payload_ff;

   a_result_after_crc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(phase_ff == PhaseCrcLow))
      else $error("result appeared without a CRC low byte");

   a_data_index_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PhaseData |-> (length_ff != '0 && byte_index_ff < length_ff))
      else $error("payload index outside announced length");

   a_length_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_length_ff <= sfrc_pkg::LengthWidth'(sfrc_pkg::MaxPayload))
      else $error("result length above limit");

endmodule

`default_nettype wire

// ===== tb/serial_frame_receive_crc_check_test.sv =====
// Self-checking test of the serial frame receiver with CRC-16/MODBUS check.
// Depends on sfrc_pkg, sfrc_req_if, sfrc_rsp_if and serial_frame_receive_crc_check.
// Drives directed and random byte streams under several register settings.
`default_nettype none

module serial_frame_receive_crc_check_test;

   localparam int IdleLimit = 3000;

   typedef enum logic [2:0] {
      PhIdle, PhType, PhLenHi, PhLenLo, PhData, PhCrcHi, PhCrcLo
   } rx_phase_type;

   typedef struct {
      logic                              kind;
      logic [sfrc_pkg::LengthWidth-1:0]  length;
      logic [sfrc_pkg::PayloadWidth-1:0] payload;
   } frame_result_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write_enable;
   sfrc_pkg::csr_index_type csr_index;
   logic [7:0]              csr_write_data;

   sfrc_req_if req_chan();
   sfrc_rsp_if rsp_chan();

   serial_frame_receive_crc_check i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_chan),
      .rsp_bus          (rsp_chan)
   );

   // Shadow registers and parser state of the frame predictor.
   logic [7:0]   cfg_head, cfg_cmd, cfg_data;
   rx_phase_type rx_phase;
   logic         rx_kind;
   logic [15:0]  rx_length;
   logic [3:0]   rx_pos;
   logic [7:0]   rx_data [sfrc_pkg::MaxPayload];
   logic [15:0]  rx_crc_sent;
   logic [15:0]  rx_crc_calc;

   frame_result_type frames_due [$];

   int mismatch_count = 0;
   int frames_checked = 0;
   int bytes_sent     = 0;
   int settings_count = 1;
   int idle_cycles    = 0;
   int burst_left     = 0;
   int stall_left     = 0;
   int stall_mode     = 0;
   int stall_tick     = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ sfrc_pkg::CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      frame_result_type fr;
      case (rx_phase)
         PhIdle: begin
            if (b == cfg_head) rx_phase = PhType;
         end
         PhType: begin
            if (b == cfg_cmd || b == cfg_data) begin
               rx_kind     = (b == cfg_cmd) ? 1'b0 : 1'b1;
               rx_pos      = 4'd0;
               rx_crc_calc = sfrc_pkg::CrcInit;
               rx_phase    = PhLenHi;
            end else begin
               rx_phase = PhIdle;
            end
         end
         PhLenHi: begin
            rx_length = {b, 8'h00};
            rx_phase  = PhLenLo;
         end
         PhLenLo: begin
            rx_length = {rx_length[15:8], b};
            if (rx_length > sfrc_pkg::MaxPayload) rx_phase = PhIdle;
            else rx_phase = (rx_length > 0) ? PhData : PhCrcHi;
         end
         PhData: begin
            if (rx_pos < sfrc_pkg::MaxPayload)
               rx_data[rx_pos[sfrc_pkg::BufIndexWidth-1:0]] = b;
            rx_pos      = rx_pos + 4'd1;
            rx_crc_calc = crc16_modbus(rx_crc_calc, b);
            if (rx_pos >= rx_length) rx_phase = PhCrcHi;
         end
         PhCrcHi: begin
            rx_crc_sent = {b, 8'h00};
            rx_phase    = PhCrcLo;
         end
         PhCrcLo: begin
            rx_crc_sent = {rx_crc_sent[15:8], b};
            if (rx_crc_sent == rx_crc_calc) begin
               fr.kind    = rx_kind;
               fr.length  = rx_length[sfrc_pkg::LengthWidth-1:0];
               fr.payload = '0;
               for (int i = 0; i < sfrc_pkg::MaxPayload && i < rx_length; i++) begin
                  fr.payload[8*i +: 8] = rx_data[i];
               end
               frames_due.push_back(fr);
            end
            rx_phase = PhIdle;
         end
         default: rx_phase = PhIdle;
      endcase
   endtask

   task automatic check_frame();
      frame_result_type want;
      if (frames_due.size() == 0) begin
         report_mismatch($sformatf("unexpected frame kind %0d length %0d payload %h",
                                   rsp_chan.frame_kind, rsp_chan.payload_length,
                                   rsp_chan.payload));
      end else begin
         want = frames_due.pop_front();
         frames_checked++;
         if (rsp_chan.frame_kind !== want.kind)
            report_mismatch($sformatf("frame %0d kind %0d, want %0d", frames_checked,
                                      rsp_chan.frame_kind, want.kind));
         if (rsp_chan.payload_length !== want.length)
            report_mismatch($sformatf("frame %0d length %0d, want %0d", frames_checked,
                                      rsp_chan.payload_length, want.length));
         if (rsp_chan.payload !== want.payload)
            report_mismatch($sformatf("frame %0d payload %h, want %h", frames_checked,
                                      rsp_chan.payload, want.payload));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_head    = sfrc_pkg::HeadByteReset;
         cfg_cmd     = sfrc_pkg::CommandTypeReset;
         cfg_data    = sfrc_pkg::DataTypeReset;
         rx_phase    = PhIdle;
         rx_kind     = 1'b0;
         rx_length   = '0;
         rx_pos      = '0;
         rx_crc_sent = '0;
         rx_crc_calc = sfrc_pkg::CrcInit;
         for (int i = 0; i < sfrc_pkg::MaxPayload; i++) rx_data[i] = 8'h00;
         idle_cycles = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_frame();
         if (req_chan.valid && req_chan.ready) predict_byte(req_chan.rx_byte);
         if (csr_write_enable) begin
            case (csr_index)
               sfrc_pkg::CsrHeadByte:    cfg_head = csr_write_data;
               sfrc_pkg::CsrCommandType: cfg_cmd  = csr_write_data;
               sfrc_pkg::CsrDataType:    cfg_data = csr_write_data;
               default: ;
            endcase
         end
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // Result side stalls according to a randomly chosen mode, redrawn at the end of each random-length run.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 150);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         2: rsp_chan.ready <= (stall_tick % 5) != 0;
         default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   initial begin
      wait (idle_cycles >= IdleLimit);
      $display("Watchdog: no transfer for %0d cycles", IdleLimit);
      $display("Mismatches found");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] type_code, input logic [15:0] length,
                             input logic [63:0] data, input logic [15:0] crc_flip);
      logic [15:0] crc;
      crc = sfrc_pkg::CrcInit;
      send_byte(cfg_head);
      send_byte(type_code);
      send_byte(length[15:8]);
      send_byte(length[7:0]);
      if (length <= sfrc_pkg::MaxPayload) begin
         for (int i = 0; i < length; i++) begin
            send_byte(data[8*i +: 8]);
            crc = crc16_modbus(crc, data[8*i +: 8]);
         end
         crc = crc ^ crc_flip;
         send_byte(crc[15:8]);
         send_byte(crc[7:0]);
      end
   endtask

   // Drop valid, wait out every expected frame, then hold off.
   task automatic settle_idle(input int hold);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (frames_due.size() != 0) @(posedge clock);
      repeat (hold) @(posedge clock);
   endtask

   task automatic program_csrs(input logic [7:0] head, input logic [7:0] cmd,
                               input logic [7:0] data);
      settle_idle(4);
      csr_write_enable <= 1'b1;
      csr_index        <= sfrc_pkg::CsrHeadByte;
      csr_write_data   <= head;
      @(posedge clock);
      csr_index      <= sfrc_pkg::CsrCommandType;
      csr_write_data <= cmd;
      @(posedge clock);
      csr_index      <= sfrc_pkg::CsrDataType;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   task automatic send_random_frame();
      int          sel;
      logic [7:0]  bad;
      logic [7:0]  code;
      logic [15:0] length;
      logic [63:0] data;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2))
            send_byte(($urandom_range(0, 4) == 0) ? cfg_head : 8'($urandom));
      end
      sel    = $urandom_range(0, 99);
      code   = $urandom_range(0, 1) ? cfg_data : cfg_cmd;
      data   = {$urandom, $urandom};
      length = 16'($urandom_range(0, sfrc_pkg::MaxPayload));
      if (sel < 5) begin
         do bad = 8'($urandom); while (bad == cfg_cmd || bad == cfg_data);
         send_byte(cfg_head);
         send_byte(bad);
      end else if (sel < 13) begin
         length = $urandom_range(0, 1) ? {8'($urandom_range(1, 255)), 8'($urandom)}
                                       : 16'($urandom_range(sfrc_pkg::MaxPayload + 1, 255));
         send_frame(code, length, data, 16'h0000);
      end else if (sel < 23) begin
         send_frame(code, length, data, 16'($urandom_range(1, 65535)));
      end else begin
         send_frame(code, length, data, 16'h0000);
      end
   endtask

   task automatic run_random_frames(input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_random_frame();
   endtask

   task automatic test_good_frames();
      send_frame(cfg_cmd, 16'd0, 64'h0, 16'h0000);
      send_frame(cfg_data, 16'd8, 64'hAA55_FE01_7F80_FF00, 16'h0000);
   endtask

   task automatic test_dropped_frames();
      send_byte(cfg_head);
      send_byte(cfg_head);
      send_frame(cfg_cmd, 16'hFFFF, 64'h0, 16'h0000);
      send_frame(cfg_data, 16'h0100, 64'h0, 16'h0000);
      send_frame(cfg_cmd, 16'd0, 64'h0, 16'h0001);
      send_frame(cfg_data, 16'd1, 64'hFF, 16'h0000);
   endtask

   task automatic test_register_settings();
      program_csrs(8'h00, 8'hFF, 8'h00);
      send_frame(cfg_cmd, 16'd2, 64'h1234, 16'h0000);
      run_random_frames(400);
      program_csrs(8'hFF, 8'h7E, 8'h7E);
      send_frame(8'h7E, 16'd3, 64'hC0FFEE, 16'h0000);
      run_random_frames(300);
      repeat (2) begin
         program_csrs(8'($urandom), 8'($urandom), 8'($urandom));
         run_random_frames(300);
      end
   endtask

   task automatic test_random_traffic();
      run_random_frames(600);
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = sfrc_pkg::CsrHeadByte;
      csr_write_data   = 8'h00;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_good_frames();
      test_dropped_frames();
      test_random_traffic();
      test_register_settings();

      settle_idle(10);
      if (frames_due.size() != 0)
         report_mismatch($sformatf("%0d expected frames never arrived", frames_due.size()));
      $display("Sent %0d bytes under %0d register settings; %0d frames compared.",
               bytes_sent, settings_count, frames_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/sfrc_pkg.sv
rtl/sfrc_req_if.sv
rtl/sfrc_rsp_if.sv
rtl/sfrc_crc16_step.sv
rtl/serial_frame_receive_crc_check.sv
tb/serial_frame_receive_crc_check_test.sv
